[hw/rtl/mieu_pkg.sv]
// Shared types and constants for the integer execute unit.
// Used by the front, queue, back and top level modules. No dependencies.
package mieu_pkg;

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADDU  = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_SUBU  = 5'd3;
    localparam logic [4:0] OP_AND   = 5'd4;
    localparam logic [4:0] OP_OR    = 5'd5;
    localparam logic [4:0] OP_XOR   = 5'd6;
    localparam logic [4:0] OP_SLT   = 5'd7;
    localparam logic [4:0] OP_SLTU  = 5'd8;
    localparam logic [4:0] OP_SLL   = 5'd9;
    localparam logic [4:0] OP_SRL   = 5'd10;
    localparam logic [4:0] OP_SRA   = 5'd11;
    localparam logic [4:0] OP_MULT  = 5'd12;
    localparam logic [4:0] OP_MULTU = 5'd13;
    localparam logic [4:0] OP_DIV   = 5'd14;
    localparam logic [4:0] OP_DIVU  = 5'd15;
    localparam logic [4:0] OP_MFHI  = 5'd16;
    localparam logic [4:0] OP_MFLO  = 5'd17;
    localparam logic [4:0] OP_MTHI  = 5'd18;
    localparam logic [4:0] OP_MTLO  = 5'd19;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QLEVEL_W = $clog2(QDEPTH + 1);
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [4:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [15:0] immediate;
        logic        use_immediate;
        logic [4:0]  shift_amount;
        logic        variable_shift;
    } issue_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_register;
        logic        overflow;
        logic        divide_by_zero;
    } done_t;

    // Classified request held in the queue: second operand already selected.
    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [4:0]  sh;
    } entry_t;

    typedef struct packed {
        logic                full;
        logic [QLEVEL_W-1:0] level;
    } qstat_t;

endpackage

[hw/rtl/mieu_front.sv]
// Front end: takes a request and resolves its operands and shift amount.
// Depends on mieu_pkg.
module mieu_front (
    input  mieu_pkg::issue_t issue,
    output mieu_pkg::entry_t entry
);

    logic [31:0] b_sext;
    logic [31:0] b_zext;

    assign b_sext = issue.use_immediate ? {{16{issue.immediate[15]}}, issue.immediate}
                                        : issue.operand_b;
    assign b_zext = issue.use_immediate ? {16'd0, issue.immediate} : issue.operand_b;

    always_comb
    begin
        entry.op = issue.operation;
        entry.a  = issue.operand_a;
        entry.sh = issue.variable_shift ? issue.operand_a[4:0] : issue.shift_amount;
        case (issue.operation) inside
            mieu_pkg::OP_ADD, mieu_pkg::OP_ADDU, mieu_pkg::OP_SUB, mieu_pkg::OP_SUBU,
            mieu_pkg::OP_SLT, mieu_pkg::OP_SLTU:
                entry.b = b_sext;
            mieu_pkg::OP_AND, mieu_pkg::OP_OR, mieu_pkg::OP_XOR:
                entry.b = b_zext;
            default:
                entry.b = issue.operand_b;
        endcase
    end

endmodule

[hw/rtl/mieu_queue.sv]
// Small FIFO between the front end and the execution back end.
// Depends on mieu_pkg.
module mieu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mieu_pkg::entry_t  wdata,
    input  logic              pop,
    output logic              valid,
    output mieu_pkg::entry_t  rdata,
    output mieu_pkg::qstat_t  stat
);

    mieu_pkg::entry_t mem [mieu_pkg::QDEPTH];

    logic [mieu_pkg::QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [mieu_pkg::QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [mieu_pkg::QLEVEL_W-1:0] level_reg, level_next;

    localparam logic [mieu_pkg::QPTR_W-1:0] PTR_LAST =
        mieu_pkg::QPTR_W'(mieu_pkg::QDEPTH - 1);
    localparam logic [mieu_pkg::QLEVEL_W-1:0] LEVEL_FULL =
        mieu_pkg::QLEVEL_W'(mieu_pkg::QDEPTH);

    assign valid      = (level_reg != '0);
    assign rdata      = mem[rptr_reg];
    assign stat.full  = (level_reg == LEVEL_FULL);
    assign stat.level = level_reg;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        level_next = level_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

endmodule

[hw/rtl/mieu_back.sv]
// Back end: executes queued requests, owns HI/LO, the multiplier, the
// iterative divider and the output register. Depends on mieu_pkg.
module mieu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mieu_pkg::entry_t  q_data,
    output logic              q_pop,
    output logic              done_valid,
    input  logic              done_stall,
    output mieu_pkg::done_t   done
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FINISH} state_t;

    state_t state_reg, state_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic        out_valid_reg, out_valid_next;
    mieu_pkg::done_t out_reg, out_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [mieu_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;

    logic        out_free;
    logic [31:0] a, b;
    logic [32:0] sum, dif;
    logic [65:0] prod_full;
    logic        sgn_mul;
    logic [32:0] rem_shift, trial;
    mieu_pkg::done_t simple;

    assign a          = q_data.a;
    assign b          = q_data.b;
    assign out_free   = !out_valid_reg || !done_stall;
    assign done_valid = out_valid_reg;
    assign done       = out_reg;
    assign q_pop      = (state_reg == S_IDLE) && q_valid && out_free;

    assign sum       = {1'b0, a} + {1'b0, b};
    assign dif       = {1'b0, a} - {1'b0, b};
    assign sgn_mul   = (q_data.op == mieu_pkg::OP_MULT);
    assign prod_full = $signed({sgn_mul & a[31], a}) * $signed({sgn_mul & b[31], b});
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign trial     = rem_shift - {1'b0, dvs_reg};

    // Results of the simple operations, computed combinationally.
    always_comb
    begin
        simple = '0;
        unique case (q_data.op)
            mieu_pkg::OP_ADD:
            begin
                if (!(a[31] ^ b[31]) && (a[31] ^ sum[31]))
                    simple.overflow = 1'b1;
                else
                begin
                    simple.result = sum[31:0];
                    simple.write_register = 1'b1;
                end
            end
            mieu_pkg::OP_SUB:
            begin
                if ((a[31] ^ b[31]) && (a[31] ^ dif[31]))
                    simple.overflow = 1'b1;
                else
                begin
                    simple.result = dif[31:0];
                    simple.write_register = 1'b1;
                end
            end
            mieu_pkg::OP_ADDU: begin simple.result = sum[31:0]; simple.write_register = 1'b1; end
            mieu_pkg::OP_SUBU: begin simple.result = dif[31:0]; simple.write_register = 1'b1; end
            mieu_pkg::OP_AND:  begin simple.result = a & b; simple.write_register = 1'b1; end
            mieu_pkg::OP_OR:   begin simple.result = a | b; simple.write_register = 1'b1; end
            mieu_pkg::OP_XOR:  begin simple.result = a ^ b; simple.write_register = 1'b1; end
            mieu_pkg::OP_SLT:
            begin
                simple.result = {31'd0, ($signed(a) < $signed(b))};
                simple.write_register = 1'b1;
            end
            mieu_pkg::OP_SLTU:
            begin
                simple.result = {31'd0, (a < b)};
                simple.write_register = 1'b1;
            end
            mieu_pkg::OP_SLL:  begin simple.result = b << q_data.sh; simple.write_register = 1'b1; end
            mieu_pkg::OP_SRL:  begin simple.result = b >> q_data.sh; simple.write_register = 1'b1; end
            mieu_pkg::OP_SRA:
            begin
                simple.result = $unsigned($signed(b) >>> q_data.sh);
                simple.write_register = 1'b1;
            end
            mieu_pkg::OP_MFHI: begin simple.result = hi_reg; simple.write_register = 1'b1; end
            mieu_pkg::OP_MFLO: begin simple.result = lo_reg; simple.write_register = 1'b1; end
            mieu_pkg::OP_DIV, mieu_pkg::OP_DIVU:
                simple.divide_by_zero = (b == 32'd0);
            default: simple = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && done_stall;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        negq_next      = negq_reg;
        negr_next      = negr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_data.op) inside
                        mieu_pkg::OP_MULT, mieu_pkg::OP_MULTU:
                        begin
                            prod_next  = prod_full[63:0];
                            state_next = S_MUL;
                        end
                        mieu_pkg::OP_DIV, mieu_pkg::OP_DIVU:
                        begin
                            if (b == 32'd0)
                            begin
                                out_next       = simple;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                // Divide magnitudes, fix the signs at the end.
                                negq_next  = (q_data.op == mieu_pkg::OP_DIV) && (a[31] ^ b[31]);
                                negr_next  = (q_data.op == mieu_pkg::OP_DIV) && a[31];
                                quo_next   = ((q_data.op == mieu_pkg::OP_DIV) && a[31]) ? -a : a;
                                dvs_next   = ((q_data.op == mieu_pkg::OP_DIV) && b[31]) ? -b : b;
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = S_DIV;
                            end
                        end
                        mieu_pkg::OP_MTHI:
                        begin
                            hi_next        = a;
                            out_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        mieu_pkg::OP_MTLO:
                        begin
                            lo_next        = a;
                            out_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_next       = simple;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                hi_next    = prod_reg[63:32];
                lo_next    = prod_reg[31:0];
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mieu_pkg::DCNT_W'(mieu_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    // HI/LO were already written by the multiply or the last divide step.
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Divide completion writes HI/LO at the last step.
        if (state_reg == S_DIV && cnt_reg == mieu_pkg::DCNT_W'(mieu_pkg::DIV_STEPS - 1))
        begin
            lo_next = negq_reg ? -quo_next : quo_next;
            hi_next = negr_reg ? -rem_next : rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

[hw/rtl/mips_integer_execute_unit.sv]
// Top level of the MIPS32 integer execute unit with HI/LO.
// Depends on mieu_pkg, mieu_front, mieu_queue and mieu_back.
//
//  channel | valid       | stall       | payload
//  request | issue_valid | issue_stall | issue (mieu_pkg::issue_t)
//  result  | done_valid  | done_stall  | done  (mieu_pkg::done_t)
//
// Simple operations are computed combinationally in the back end; a request enters the
// two-entry queue while the back end works on an earlier one.
// Multiply registers the product, then writes HI/LO, then registers the result.
// Divide has one setup step, 32 one-bit steps of the shared divider and one result step.
// issue_stall is high only while the queue is full; reset clears queue, HI, LO and state.
module mips_integer_execute_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             issue_valid,
    output logic             issue_stall,
    input  mieu_pkg::issue_t issue,
    output logic             done_valid,
    input  logic             done_stall,
    output mieu_pkg::done_t  done
);

    mieu_pkg::entry_t front_entry;
    mieu_pkg::entry_t q_data;
    mieu_pkg::qstat_t q_stat;
    logic             q_valid;
    logic             q_pop;
    logic             push;

    assign issue_stall = q_stat.full;
    assign push        = issue_valid && !issue_stall;

    mieu_front u_front (
        .issue (issue),
        .entry (front_entry)
    );

    mieu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_entry),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_data),
        .stat  (q_stat)
    );

    mieu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .done_valid (done_valid),
        .done_stall (done_stall),
        .done       (done)
    );

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (q_stat.level == $past(q_stat.level) + 1'b1))
        else $error("queue level did not follow a push");

    a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (done_valid && done.overflow) |-> (!done.write_register && done.result == 32'd0))
        else $error("overflow result writes a register");

    a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (done_valid && done.divide_by_zero) |-> (!done.write_register && !done.overflow))
        else $error("divide by zero result writes a register");

endmodule
